/* rtl/core/phr_pkg.sv */
// ----------------------------------------------------------------------------
// phr_pkg
// Shared types and constants of the pixel hue rotator.
// ----------------------------------------------------------------------------
package phr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SHIFT_W       = 9;
    localparam int DEG_TURN      = 360;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    typedef struct packed {
        pixel_in_t  pix;
        logic [7:0] vmax;
        logic       bypass;
        logic [2:0] sext_base;
        logic       neg;
    } prep_t;

endpackage

/* rtl/core/pixel_hue_rotate.sv */
// ----------------------------------------------------------------------------
// pixel_hue_rotate
// Rotates the hue of an 8-bit RGB pixel stream by a configured angle.
// ----------------------------------------------------------------------------
// Pixels arrive on pix with pix_valid; a transfer happens at a clock edge
// where pix_valid is high and pix_stall is low. Results leave on res with
// res_valid, and a transfer completes where res_valid is high and
// res_stall is low.
// The hue shift in degrees is written through cfg_we and cfg_data; the user
// must write it only while the stream is idle, which the block itself does
// not enforce. Values of 360 and above wrap around the circle. The pipeline
// has one preparation stage, one divider stage per quotient bit, a hue stage
// and two multiplier stages that end in the output register. Throughput is
// one pixel per clock unless the receiver stalls. The whole pipeline
// advances together, so when the receiver stalls a valid result, every
// stage holds and pix_stall goes high in the same cycle; nothing is dropped
// or repeated. Reset clears all valid bits and sets the hue shift to zero.
// ----------------------------------------------------------------------------
module pixel_hue_rotate #(
    parameter int FRAC_BITS = phr_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  phr_pkg::pixel_in_t            pix,
    output logic                          res_valid,
    input  logic                          res_stall,
    output phr_pkg::pixel_out_t           res,
    input  logic                          cfg_we,
    input  logic [phr_pkg::SHIFT_W-1:0]   cfg_data
);
    import phr_pkg::*;

    localparam int SIDE_W = $bits(prep_t) + FRAC_BITS + 3;

    logic                 en;
    logic [SHIFT_W-1:0]   hue_shift_reg;

    logic                 prep_valid;
    prep_t                prep_side;
    logic [FRAC_BITS+2:0] prep_sh;
    logic [7:0]           snum, sden, hnum, hden;

    logic                 div_valid;
    logic [SIDE_W-1:0]    div_side;
    logic [FRAC_BITS:0]   sq, hq;
    logic                 hrem_nz;
    prep_t                div_prep;
    logic [FRAC_BITS+2:0] div_sh;

    logic                 hsv_valid;
    prep_t                hsv_side;
    logic [FRAC_BITS-1:0] sat, ff;
    logic [2:0]           sext;

    assign en        = !(res_valid && res_stall);
    assign pix_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_shift_reg <= '0;
        end
        else if (cfg_we)
        begin
            hue_shift_reg <= cfg_data;
        end
    end

    phr_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_valid),
        .pix       (pix),
        .hue_shift (hue_shift_reg),
        .out_valid (prep_valid),
        .side      (prep_side),
        .sh        (prep_sh),
        .snum      (snum),
        .sden      (sden),
        .hnum      (hnum),
        .hden      (hden)
    );

    phr_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .side_in   ({prep_side, prep_sh}),
        .snum      (snum),
        .sden      (sden),
        .hnum      (hnum),
        .hden      (hden),
        .out_valid (div_valid),
        .side_out  (div_side),
        .sq        (sq),
        .hq        (hq),
        .hrem_nz   (hrem_nz)
    );

    assign div_prep = div_side[SIDE_W-1:FRAC_BITS+3];
    assign div_sh   = div_side[FRAC_BITS+2:0];

    phr_hsv #(.FRAC_BITS(FRAC_BITS)) u_hsv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .side      (div_prep),
        .sh        (div_sh),
        .sq        (sq),
        .hq        (hq),
        .hrem_nz   (hrem_nz),
        .out_valid (hsv_valid),
        .side_out  (hsv_side),
        .sat       (sat),
        .sext      (sext),
        .ff        (ff)
    );

    phr_rebuild #(.FRAC_BITS(FRAC_BITS)) u_rebuild (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hsv_valid),
        .side      (hsv_side),
        .sat       (sat),
        .sext      (sext),
        .ff        (ff),
        .out_valid (res_valid),
        .res       (res)
    );

endmodule

/* rtl/core/phr_prep.sv */
// ----------------------------------------------------------------------------
// phr_prep
// First stage: channel maximum and minimum, hue sector, divider operands
// and the hue shift in sextant units.
// ----------------------------------------------------------------------------
module phr_prep #(
    parameter int FRAC_BITS = phr_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  phr_pkg::pixel_in_t                pix,
    input  logic [phr_pkg::SHIFT_W-1:0]       hue_shift,
    output logic                              out_valid,
    output phr_pkg::prep_t                    side,
    output logic [FRAC_BITS+2:0]              sh,
    output logic [7:0]                        snum,
    output logic [7:0]                        sden,
    output logic [7:0]                        hnum,
    output logic [7:0]                        hden
);
    import phr_pkg::*;

    logic [7:0]           r, g, b, mx, mn, delta, mag;
    logic [8:0]           diff;
    logic [2:0]           base;
    logic [SHIFT_W-1:0]   hs;
    logic [19:0]          prod;
    logic [2:0]           turns;
    logic [5:0]           rest;
    logic [FRAC_BITS-1:0] shf_tab [64];

    logic                 valid_reg;
    prep_t                side_reg;
    logic [FRAC_BITS+2:0] sh_reg;
    logic [7:0]           hnum_reg;
    logic [7:0]           snum_reg;

    for (genvar i = 0; i < 64; i++) begin : g_tab
        if (i < 60) begin : g_val
            assign shf_tab[i] = FRAC_BITS'((longint'(i) << FRAC_BITS) / 60);
        end else begin : g_pad
            assign shf_tab[i] = '0;
        end
    end

    always_comb
    begin
        r = pix.red_in;
        g = pix.green_in;
        b = pix.blue_in;
        mx = (r >= g) ? r : g;
        mx = (mx >= b) ? mx : b;
        mn = (r <= g) ? r : g;
        mn = (mn <= b) ? mn : b;
        delta = mx - mn;
        if (r == mx)
        begin
            base = 3'd0;
            diff = {1'b0, g} - {1'b0, b};
        end
        else if (g == mx)
        begin
            base = 3'd2;
            diff = {1'b0, b} - {1'b0, r};
        end
        else
        begin
            base = 3'd4;
            diff = {1'b0, r} - {1'b0, g};
        end
        mag = diff[8] ? 8'(-diff) : diff[7:0];

        hs    = (hue_shift >= SHIFT_W'(DEG_TURN)) ? hue_shift - SHIFT_W'(DEG_TURN) : hue_shift;
        prod  = 20'(hs) * 20'd1093;
        turns = prod[18:16];
        rest  = 6'(hs - SHIFT_W'(turns) * SHIFT_W'(60));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg.pix       <= pix;
            side_reg.vmax      <= mx;
            side_reg.bypass    <= (delta == 8'd0);
            side_reg.sext_base <= base;
            side_reg.neg       <= diff[8];
            sh_reg             <= {turns, shf_tab[rest]};
            hnum_reg           <= mag;
            snum_reg           <= delta;
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign sh        = sh_reg;
    assign snum      = snum_reg;
    assign sden      = side_reg.vmax;
    assign hnum      = hnum_reg;
    assign hden      = snum_reg;

endmodule

/* rtl/core/phr_div.sv */
// ----------------------------------------------------------------------------
// phr_div
// Pipelined restoring divider pair, one quotient bit per stage, for the
// saturation and the hue fraction.
// ----------------------------------------------------------------------------
module phr_div #(
    parameter int FRAC_BITS = phr_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SIDE_W-1:0]    side_in,
    input  logic [7:0]           snum,
    input  logic [7:0]           sden,
    input  logic [7:0]           hnum,
    input  logic [7:0]           hden,
    output logic                 out_valid,
    output logic [SIDE_W-1:0]    side_out,
    output logic [FRAC_BITS:0]   sq,
    output logic [FRAC_BITS:0]   hq,
    output logic                 hrem_nz
);
    import phr_pkg::*;

    localparam int STAGES = FRAC_BITS + 1;

    logic                 v_reg    [STAGES];
    logic [SIDE_W-1:0]    side_reg [STAGES];
    logic [7:0]           srem_reg [STAGES];
    logic [7:0]           hrem_reg [STAGES];
    logic [7:0]           sden_reg [STAGES];
    logic [7:0]           hden_reg [STAGES];
    logic [FRAC_BITS:0]   sq_reg   [STAGES];
    logic [FRAC_BITS:0]   hq_reg   [STAGES];

    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic [7:0] den,
                                            input logic first);
        logic [8:0] trial;
        logic [8:0] res;
        trial = first ? {1'b0, rem} : {rem, 1'b0};
        if (trial >= {1'b0, den})
        begin
            res = {1'b1, 8'(trial - {1'b0, den})};
        end
        else
        begin
            res = {1'b0, trial[7:0]};
        end
        return res;
    endfunction

    for (genvar k = 0; k < STAGES; k++) begin : g_st
        logic               v_prev;
        logic [SIDE_W-1:0]  side_prev;
        logic [7:0]         srem_prev, hrem_prev, sden_prev, hden_prev;
        logic [FRAC_BITS:0] sq_prev, hq_prev;
        logic [8:0]         s_res, h_res;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign side_prev = side_in;
            assign srem_prev = snum;
            assign hrem_prev = hnum;
            assign sden_prev = sden;
            assign hden_prev = hden;
            assign sq_prev   = '0;
            assign hq_prev   = '0;
        end else begin : g_next
            assign v_prev    = v_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign srem_prev = srem_reg[k-1];
            assign hrem_prev = hrem_reg[k-1];
            assign sden_prev = sden_reg[k-1];
            assign hden_prev = hden_reg[k-1];
            assign sq_prev   = sq_reg[k-1];
            assign hq_prev   = hq_reg[k-1];
        end

        assign s_res = div_step(srem_prev, sden_prev, (k == 0));
        assign h_res = div_step(hrem_prev, hden_prev, (k == 0));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_prev;
                srem_reg[k] <= s_res[7:0];
                hrem_reg[k] <= h_res[7:0];
                sden_reg[k] <= sden_prev;
                hden_reg[k] <= hden_prev;
                sq_reg[k]   <= {sq_prev[FRAC_BITS-1:0], s_res[8]};
                hq_reg[k]   <= {hq_prev[FRAC_BITS-1:0], h_res[8]};
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];
    assign sq        = sq_reg[STAGES-1];
    assign hq        = hq_reg[STAGES-1];
    assign hrem_nz   = (hrem_reg[STAGES-1] != 8'd0);

endmodule

/* rtl/core/phr_hsv.sv */
// ----------------------------------------------------------------------------
// phr_hsv
// Forms the clamped saturation and the shifted hue, wrapped to one turn.
// ----------------------------------------------------------------------------
module phr_hsv #(
    parameter int FRAC_BITS = phr_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  phr_pkg::prep_t        side,
    input  logic [FRAC_BITS+2:0]  sh,
    input  logic [FRAC_BITS:0]    sq,
    input  logic [FRAC_BITS:0]    hq,
    input  logic                  hrem_nz,
    output logic                  out_valid,
    output phr_pkg::prep_t        side_out,
    output logic [FRAC_BITS-1:0]  sat,
    output logic [2:0]            sext,
    output logic [FRAC_BITS-1:0]  ff
);
    import phr_pkg::*;

    localparam int HW = FRAC_BITS + 5;
    localparam logic signed [HW-1:0] TURN = HW'(6) <<< FRAC_BITS;

    logic signed [HW-1:0] base_v, frac_v, sh_v, hue, hue_w;
    logic [FRAC_BITS-1:0] sat_c;

    logic                 valid_reg;
    prep_t                side_reg;
    logic [FRAC_BITS-1:0] sat_reg, ff_reg;
    logic [2:0]           sext_reg;

    always_comb
    begin
        sat_c  = sq[FRAC_BITS] ? {FRAC_BITS{1'b1}} : sq[FRAC_BITS-1:0];
        base_v = $signed(HW'(side.sext_base) << FRAC_BITS);
        frac_v = $signed(HW'(hq) + HW'(hrem_nz && side.neg));
        if (side.neg)
        begin
            frac_v = -frac_v;
        end
        sh_v  = $signed(HW'(sh));
        hue   = base_v + frac_v + sh_v;
        hue_w = hue;
        if (hue < 0)
        begin
            hue_w = hue + TURN;
        end
        else if (hue >= TURN)
        begin
            hue_w = hue - TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side;
            sat_reg  <= sat_c;
            sext_reg <= hue_w[FRAC_BITS+2:FRAC_BITS];
            ff_reg   <= hue_w[FRAC_BITS-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign side_out  = side_reg;
    assign sat       = sat_reg;
    assign sext      = sext_reg;
    assign ff        = ff_reg;

endmodule

/* rtl/core/phr_rebuild.sv */
// ----------------------------------------------------------------------------
// phr_rebuild
// Computes p, q and t over two multiplier stages and selects the output
// channels by hue sextant into the output register; grey pixels pass through unchanged.
// ----------------------------------------------------------------------------
module phr_rebuild #(
    parameter int FRAC_BITS = phr_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  phr_pkg::prep_t        side,
    input  logic [FRAC_BITS-1:0]  sat,
    input  logic [2:0]            sext,
    input  logic [FRAC_BITS-1:0]  ff,
    output logic                  out_valid,
    output phr_pkg::pixel_out_t   res
);
    import phr_pkg::*;

    localparam int PW = 2 * FRAC_BITS + 1;
    localparam int MW = FRAC_BITS + 9;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [PW-1:0]        sf_prod, st_prod;
    logic [MW-1:0]        p_prod, q_prod, t_prod;
    logic [7:0]           q_c, t_c;
    pixel_out_t           res_next;

    logic                 v1_reg;
    prep_t                side1_reg;
    logic [2:0]           sext1_reg;
    logic [FRAC_BITS-1:0] sf_reg, st_reg;
    logic [7:0]           p_reg;
    logic                 v2_reg;
    pixel_out_t           res_reg;

    always_comb
    begin
        sf_prod = PW'(sat) * PW'(ff);
        st_prod = PW'(sat) * PW'(ONE - {1'b0, ff});
        p_prod  = MW'(side.vmax) * MW'(ONE - {1'b0, sat});
    end

    always_comb
    begin
        q_prod = MW'(side1_reg.vmax) * MW'(ONE - {1'b0, sf_reg});
        t_prod = MW'(side1_reg.vmax) * MW'(ONE - {1'b0, st_reg});
        q_c    = q_prod[FRAC_BITS+7:FRAC_BITS];
        t_c    = t_prod[FRAC_BITS+7:FRAC_BITS];
        case (sext1_reg)
            3'd0:    res_next = '{side1_reg.vmax, t_c, p_reg};
            3'd1:    res_next = '{q_c, side1_reg.vmax, p_reg};
            3'd2:    res_next = '{p_reg, side1_reg.vmax, t_c};
            3'd3:    res_next = '{p_reg, q_c, side1_reg.vmax};
            3'd4:    res_next = '{t_c, p_reg, side1_reg.vmax};
            default: res_next = '{side1_reg.vmax, p_reg, q_c};
        endcase
        if (side1_reg.bypass)
        begin
            res_next = '{side1_reg.pix.red_in, side1_reg.pix.green_in, side1_reg.pix.blue_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side;
            sext1_reg <= sext;
            sf_reg    <= sf_prod[2*FRAC_BITS-1:FRAC_BITS];
            st_reg    <= st_prod[2*FRAC_BITS-1:FRAC_BITS];
            p_reg     <= p_prod[FRAC_BITS+7:FRAC_BITS];
            res_reg   <= res_next;
        end
    end

    assign out_valid = v2_reg;
    assign res       = res_reg;

endmodule
